// ----- src/cfuv_pkg.sv -----
// Shared constants, item types and face codes of the cube-map face and coordinate selector.
`default_nettype none

package cfuv_pkg;

   // Width of one direction component and fraction bits of a face coordinate
   localparam int COMPONENT_WIDTH     = 16;
   localparam int COORD_FRACTION_BITS = 16;

   // Fixed widths of the channel fields
   localparam int FIELD_WIDTH = 16;

   // Divisor 2*|major| needs one bit more than a component; a doubled
   // partial remainder needs one more again
   localparam int DIVISOR_WIDTH = COMPONENT_WIDTH + 1;
   localparam int PARTIAL_WIDTH = COMPONENT_WIDTH + 2;

   // Queue between front and back; depth is a power of two so pointers wrap
   localparam int QUEUE_DEPTH       = 2;
   localparam int QUEUE_INDEX_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef logic [DIVISOR_WIDTH-1:0] div_type;

   typedef enum logic [2:0] {
      FACE_RIGHT  = 3'd0,
      FACE_LEFT   = 3'd1,
      FACE_TOP    = 3'd2,
      FACE_BOTTOM = 3'd3,
      FACE_FRONT  = 3'd4,
      FACE_BACK   = 3'd5
   } face_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] dir_x;
      logic signed [FIELD_WIDTH-1:0] dir_y;
      logic signed [FIELD_WIDTH-1:0] dir_z;
   } req_item_type;

   typedef struct packed {
      face_type                face;
      logic [FIELD_WIDTH-1:0]  tex_u;
      logic [FIELD_WIDTH-1:0]  tex_v;
   } rsp_item_type;

   // Classified item: face, divisor 2*|major| and the two numerators (0..divisor)
   typedef struct packed {
      face_type face;
      div_type  divisor;
      div_type  num_u;
      div_type  num_v;
   } work_item_type;

endpackage

`default_nettype wire

// ----- src/cfuv_front.sv -----
// Front end: picks the major axis and face and forms divisor and numerators of an item.
`default_nettype none

module cfuv_front (
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cfuv_pkg::req_item_type  req_item,
   input  logic                    queue_full,
   output logic                    push_valid,
   output cfuv_pkg::work_item_type work_item
);

   localparam int CW = cfuv_pkg::COMPONENT_WIDTH;
   localparam int PW = cfuv_pkg::PARTIAL_WIDTH;
   localparam int DW = cfuv_pkg::DIVISOR_WIDTH;

   logic signed [CW-1:0] comp_x;
   logic signed [CW-1:0] comp_y;
   logic signed [CW-1:0] comp_z;
   logic [CW-1:0]        mag_x;
   logic [CW-1:0]        mag_y;
   logic [CW-1:0]        mag_z;
   logic                 x_major;
   logic                 y_major;
   logic                 neg;
   logic                 zero_vec;
   logic [CW-1:0]        mag_major;
   logic signed [CW-1:0] minor_u;
   logic signed [CW-1:0] minor_v;
   logic                 flip_u;
   logic                 flip_v;
   cfuv_pkg::face_type   face;

   // Numerator n = minor*sign(major) + |major|, flipped to 2|major| - n on request
   function automatic cfuv_pkg::div_type face_num(
      input logic signed [CW-1:0] minor,
      input logic                 major_neg,
      input logic [CW-1:0]        major_mag,
      input logic                 flip
   );
      logic signed [PW-1:0] wide;
      logic signed [PW-1:0] sum;
      cfuv_pkg::div_type    num;
      cfuv_pkg::div_type    dvs;
      wide = PW'(minor);
      if (major_neg) begin
         wide = -wide;
      end
      sum = wide + $signed({2'b00, major_mag});
      num = sum[DW-1:0];
      dvs = {major_mag, 1'b0};
      if (flip) begin
         num = dvs - num;
      end
      return num;
   endfunction

   // Read components as CW-bit two's complement values and take magnitudes
   always_comb begin
      comp_x = CW'($unsigned(req_item.dir_x));
      comp_y = CW'($unsigned(req_item.dir_y));
      comp_z = CW'($unsigned(req_item.dir_z));
      mag_x  = comp_x[CW-1] ? -comp_x : comp_x;
      mag_y  = comp_y[CW-1] ? -comp_y : comp_y;
      mag_z  = comp_z[CW-1] ? -comp_z : comp_z;
      x_major = (mag_x >= mag_y) && (mag_x >= mag_z);
      y_major = (mag_y >= mag_x) && (mag_y >= mag_z);
   end

   // Select face, major magnitude, minor components and flips; x wins ties, then y
   always_comb begin
      neg       = 1'b0;
      zero_vec  = 1'b0;
      mag_major = '0;
      minor_u   = '0;
      minor_v   = '0;
      flip_u    = 1'b0;
      flip_v    = 1'b0;
      face      = cfuv_pkg::FACE_TOP;
      if (x_major) begin
         neg       = comp_x[CW-1];
         zero_vec  = (mag_x == '0);
         mag_major = mag_x;
         minor_u   = comp_z;
         minor_v   = comp_y;
         flip_v    = neg;
         if (zero_vec) begin
            face = cfuv_pkg::FACE_TOP;
         end else if (neg) begin
            face = cfuv_pkg::FACE_LEFT;
         end else begin
            face = cfuv_pkg::FACE_RIGHT;
         end
      end else if (y_major) begin
         neg       = comp_y[CW-1];
         mag_major = mag_y;
         minor_u   = comp_x;
         minor_v   = comp_z;
         flip_u    = neg;
         flip_v    = neg;
         if (neg) begin
            face = cfuv_pkg::FACE_BOTTOM;
         end else begin
            face = cfuv_pkg::FACE_TOP;
         end
      end else begin
         neg       = comp_z[CW-1];
         mag_major = mag_z;
         minor_u   = comp_x;
         minor_v   = comp_y;
         flip_u    = !neg;
         flip_v    = neg;
         if (neg) begin
            face = cfuv_pkg::FACE_BACK;
         end else begin
            face = cfuv_pkg::FACE_FRONT;
         end
      end
   end

   // Build the work item; a zero vector divides zero by one so both coordinates are zero
   always_comb begin
      work_item.face = face;
      if (zero_vec) begin
         work_item.divisor = DW'(1);
         work_item.num_u   = '0;
         work_item.num_v   = '0;
      end else begin
         work_item.divisor = {mag_major, 1'b0};
         work_item.num_u   = face_num(minor_u, neg, mag_major, flip_u);
         work_item.num_v   = face_num(minor_v, neg, mag_major, flip_v);
      end
   end

   // Hold the requester while the queue is full
   assign req_stall  = queue_full;
   assign push_valid = req_valid && !queue_full;

endmodule

`default_nettype wire

// ----- src/cfuv_queue.sv -----
// Short queue of classified items between the front end and the divider pipeline.
`default_nettype none

module cfuv_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  cfuv_pkg::work_item_type push_item,
   output logic                    full,
   output logic                    head_valid,
   input  logic                    head_ready,
   output cfuv_pkg::work_item_type head_item
);

   localparam int DEPTH = cfuv_pkg::QUEUE_DEPTH;
   localparam int IW    = cfuv_pkg::QUEUE_INDEX_WIDTH;
   localparam int CNTW  = cfuv_pkg::QUEUE_COUNT_WIDTH;

   cfuv_pkg::work_item_type mem_ff [DEPTH];
   logic [IW-1:0]           wr_ptr_ff;
   logic [IW-1:0]           wr_ptr_in;
   logic [IW-1:0]           rd_ptr_ff;
   logic [IW-1:0]           rd_ptr_in;
   logic [CNTW-1:0]         count_ff;
   logic [CNTW-1:0]         count_in;
   logic                    push;
   logic                    pop;

   // Status and handshakes
   assign full       = (count_ff == CNTW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign push       = push_valid && !full;
   assign pop        = head_valid && head_ready;
   assign head_item  = mem_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed items
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Fill level follows pushes and pops
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (count_ff == CNTW'($past(count_ff) + CNTW'($past(push)) - CNTW'($past(pop)))))
      else $error("queue count out of step with pushes and pops");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("queue count above depth");

endmodule

`default_nettype wire

// ----- src/cfuv_back.sv -----
// Back end: divider pipeline forming one quotient bit per stage, and the result register.
`default_nettype none

module cfuv_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   output logic                    head_ready,
   input  cfuv_pkg::work_item_type head_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cfuv_pkg::rsp_item_type  rsp_item
);

   localparam int FB = cfuv_pkg::COORD_FRACTION_BITS;
   localparam int DW = cfuv_pkg::DIVISOR_WIDTH;
   localparam int PW = cfuv_pkg::PARTIAL_WIDTH;
   localparam int OW = cfuv_pkg::FIELD_WIDTH;

   logic [FB-1:0]          valid_ff;
   logic [FB-1:0]          valid_in;
   cfuv_pkg::face_type     face_ff    [FB];
   cfuv_pkg::div_type      div_ff     [FB];
   cfuv_pkg::div_type      rem_u_ff   [FB];
   cfuv_pkg::div_type      rem_v_ff   [FB];
   logic [FB-1:0]          quo_u_ff   [FB];
   logic [FB-1:0]          quo_v_ff   [FB];

   cfuv_pkg::face_type     face_src   [FB];
   cfuv_pkg::div_type      div_src    [FB];
   cfuv_pkg::div_type      rem_u_src  [FB];
   cfuv_pkg::div_type      rem_v_src  [FB];
   logic [FB-1:0]          quo_u_src  [FB];
   logic [FB-1:0]          quo_v_src  [FB];
   logic [DW:0]            step_u     [FB];
   logic [DW:0]            step_v     [FB];
   cfuv_pkg::div_type      rem_u_in   [FB];
   cfuv_pkg::div_type      rem_v_in   [FB];
   logic [FB-1:0]          quo_u_in   [FB];
   logic [FB-1:0]          quo_v_in   [FB];

   logic                   rsp_valid_ff;
   cfuv_pkg::rsp_item_type rsp_ff;
   logic                   advance;

   // One restoring division step: returns {quotient bit, new remainder}
   function automatic logic [DW:0] div_step(
      input cfuv_pkg::div_type rem,
      input cfuv_pkg::div_type dvs
   );
      logic [PW-1:0] shifted;
      logic [PW-1:0] diff;
      shifted = {rem, 1'b0};
      diff    = shifted - PW'(dvs);
      if (shifted >= PW'(dvs)) begin
         return {1'b1, diff[DW-1:0]};
      end else begin
         return {1'b0, shifted[DW-1:0]};
      end
   endfunction

   // Move the whole pipe while the result register is empty or being taken
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign head_ready = advance;

   // Feed stage 0 from the queue head and every other stage from the one before
   always_comb begin
      valid_in[0]  = head_valid;
      face_src[0]  = head_item.face;
      div_src[0]   = head_item.divisor;
      rem_u_src[0] = head_item.num_u;
      rem_v_src[0] = head_item.num_v;
      quo_u_src[0] = '0;
      quo_v_src[0] = '0;
      for (int s = 1; s < FB; s++) begin
         valid_in[s]  = valid_ff[s-1];
         face_src[s]  = face_ff[s-1];
         div_src[s]   = div_ff[s-1];
         rem_u_src[s] = rem_u_ff[s-1];
         rem_v_src[s] = rem_v_ff[s-1];
         quo_u_src[s] = quo_u_ff[s-1];
         quo_v_src[s] = quo_v_ff[s-1];
      end
   end

   // Each stage adds one quotient bit to both coordinates
   always_comb begin
      for (int s = 0; s < FB; s++) begin
         step_u[s]   = div_step(rem_u_src[s], div_src[s]);
         step_v[s]   = div_step(rem_v_src[s], div_src[s]);
         rem_u_in[s] = step_u[s][DW-1:0];
         rem_v_in[s] = step_v[s][DW-1:0];
         quo_u_in[s] = {quo_u_src[s][FB-2:0], step_u[s][DW]};
         quo_v_in[s] = {quo_v_src[s][FB-2:0], step_v[s][DW]};
      end
   end

   // Valid bits of the stages and of the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[FB-1];
      end
   end

   // Stage payloads and the result; a numerator equal to the divisor gives all ones
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < FB; s++) begin
            face_ff[s]  <= face_src[s];
            div_ff[s]   <= div_src[s];
            rem_u_ff[s] <= rem_u_in[s];
            rem_v_ff[s] <= rem_v_in[s];
            quo_u_ff[s] <= quo_u_in[s];
            quo_v_ff[s] <= quo_v_in[s];
         end
         rsp_ff.face  <= face_ff[FB-1];
         rsp_ff.tex_u <= OW'(quo_u_ff[FB-1]);
         rsp_ff.tex_v <= OW'(quo_v_ff[FB-1]);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // A held result freezes every stage
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(valid_ff))
      else $error("divider stages moved while the result was held");

   // A popped queue head enters stage 0
   assert property (@(posedge clock) disable iff (reset)
      head_valid && head_ready |=> valid_ff[0])
      else $error("popped item missing from stage 0");

   // Partial remainders of the last stage never exceed the divisor
   assert property (@(posedge clock) disable iff (reset)
      valid_ff[FB-1] |-> (rem_u_ff[FB-1] <= div_ff[FB-1]) && (rem_v_ff[FB-1] <= div_ff[FB-1]))
      else $error("remainder above divisor in last stage");

endmodule

`default_nettype wire

// ----- src/cubemap_face_uv_select.sv -----
// Top level of the cube-map face and coordinate selector.
//
// One request item carries a direction (dir_x, dir_y, dir_z, signed). Each
// gives one response item: the face of the major axis (x wins ties, then y)
// and the face coordinates tex_u, tex_v as unsigned Q0.16 fractions, 1.0
// saturating to all ones. A zero direction gives the top face at (0, 0).
// Both channels use valid/stall; an item moves when valid is high and stall
// is low.
// Throughput: one item per cycle while neither channel stalls. Each item
// passes the queue, the 16 divider stages (one quotient bit per divider
// stage) and the result register.
// The front end classifies items into a two-entry queue; req_stall is high
// while that queue is full. While a result waits under rsp_stall, the result
// register and the divider stages freeze, the queue takes at most two more
// items, and then req_stall rises. Synchronous reset empties the queue and
// the pipeline; no response is pending after reset.
`default_nettype none

module cubemap_face_uv_select (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cfuv_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cfuv_pkg::rsp_item_type rsp_item
);

   logic                    push_valid;
   logic                    queue_full;
   logic                    head_valid;
   logic                    head_ready;
   cfuv_pkg::work_item_type work_item;
   cfuv_pkg::work_item_type head_item;

   // Classify incoming directions
   cfuv_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .work_item  (work_item)
   );

   // Decouple classification from division
   cfuv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (work_item),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .head_item  (head_item)
   );

   // Divide and deliver results
   cfuv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_ready (head_ready),
      .head_item  (head_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// ----- tb/sv/tb_cubemap_face_uv_select.sv -----
// Self-checking testbench for the cube-map face and coordinate selector.
`timescale 1ns / 100ps

module tb_cubemap_face_uv_select;
   import cfuv_pkg::*;

   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_COUNT   = 450;
   localparam int HOLD_TRIGGER   = 150;
   localparam int HOLD_CYCLES    = 150;
   localparam int TAIL_CYCLES    = 40;

   // One row of the directed table; the expected result is typed in only when
   // exact is set, otherwise the predictor supplies it
   typedef struct packed {
      req_item_type req;
      logic         exact;
      rsp_item_type want;
   } stim_row_type;

   localparam rsp_item_type PREDICTED = '{FACE_RIGHT, 16'h0000, 16'h0000};

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   rsp_item_type expected_face_uv [$];
   int mismatch_count     = 0;
   int accepted_count     = 0;
   int rsp_count          = 0;
   int input_stall_cycles = 0;
   int face_hits [6]      = '{default: 0};
   int hold_left          = 0;
   bit hold_done          = 1'b0;
   int burst_left         = 0;
   int idle_due           = 0;

   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      // zero vector, axis extremes, ties and saturation
      '{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{FACE_TOP, 16'h0000, 16'h0000}},
      '{'{16'sd32767, 16'sd0, 16'sd0}, 1'b1, '{FACE_RIGHT, 16'h8000, 16'h8000}},
      '{'{16'sh8000, 16'sd0, 16'sd0}, 1'b1, '{FACE_LEFT, 16'h8000, 16'h8000}},
      '{'{16'sd0, 16'sd32767, 16'sd0}, 1'b1, '{FACE_TOP, 16'h8000, 16'h8000}},
      '{'{16'sd0, 16'sh8000, 16'sd0}, 1'b1, '{FACE_BOTTOM, 16'h8000, 16'h8000}},
      '{'{16'sd0, 16'sd0, 16'sd32767}, 1'b1, '{FACE_FRONT, 16'h8000, 16'h8000}},
      '{'{16'sd0, 16'sd0, 16'sh8000}, 1'b1, '{FACE_BACK, 16'h8000, 16'h8000}},
      '{'{16'sd100, 16'sd100, 16'sd100}, 1'b1, '{FACE_RIGHT, 16'hffff, 16'hffff}},
      '{'{16'sh8000, 16'sh8000, 16'sh8000}, 1'b1, '{FACE_LEFT, 16'hffff, 16'h0000}},
      '{'{16'sd1, -16'sd1, 16'sd0}, 1'b1, '{FACE_RIGHT, 16'h8000, 16'h0000}},
      '{'{16'sd0, 16'sd5, -16'sd5}, 1'b1, '{FACE_TOP, 16'h8000, 16'h0000}},
      '{'{16'sd0, 16'sd0, -16'sd1}, 1'b1, '{FACE_BACK, 16'h8000, 16'h8000}},
      '{'{-16'sd1, 16'sd0, 16'sd0}, 1'b1, '{FACE_LEFT, 16'h8000, 16'h8000}},
      '{'{16'sd0, 16'sd1, 16'sd1}, 1'b1, '{FACE_TOP, 16'h8000, 16'hffff}},
      '{'{16'sd0, -16'sd7, 16'sd7}, 1'b1, '{FACE_BOTTOM, 16'h8000, 16'hffff}},
      // general directions on the right, left, bottom, front and back faces
      '{'{16'sd12345, -16'sd2000, 16'sd3000}, 1'b0, PREDICTED},
      '{'{-16'sd7, 16'sd3, -16'sd6}, 1'b0, PREDICTED},
      '{'{16'sd5, -16'sd9, 16'sd2}, 1'b0, PREDICTED},
      '{'{-16'sd3, 16'sd7, -16'sd12}, 1'b0, PREDICTED},
      '{'{16'sd4, -16'sd1, 16'sd9}, 1'b0, PREDICTED},
      '{'{16'sh8000, 16'sd32767, -16'sd32767}, 1'b0, PREDICTED},
      '{'{16'sd32767, 16'sh8000, 16'sd0}, 1'b0, PREDICTED},
      '{'{16'sd3, -16'sd1, -16'sd3}, 1'b0, PREDICTED},
      '{'{-16'sd20000, 16'sd30000, -16'sd31000}, 1'b0, PREDICTED},
      '{'{16'sd1, -16'sd32767, 16'sd32767}, 1'b0, PREDICTED}
   };

   cubemap_face_uv_select dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Map a minor component against a nonzero major one to t or 1-t, Q0.16
   function automatic logic [FIELD_WIDTH-1:0] minor_to_coord(longint minor, longint major,
                                                             bit flip);
      longint span;
      longint num;
      longint quo;
      span = (major < 0) ? -major : major;
      num  = ((major < 0) ? -minor : minor) + span;
      if (num < 0) num = 0;
      if (num > 2 * span) num = 2 * span;
      if (flip) num = 2 * span - num;
      quo = (num << COORD_FRACTION_BITS) / (2 * span);
      if (quo >= (longint'(1) << COORD_FRACTION_BITS))
         quo = (longint'(1) << COORD_FRACTION_BITS) - 1;
      return quo[FIELD_WIDTH-1:0];
   endfunction

   // Pick the face of the major axis (x, then y, then z on ties) and its u, v
   function automatic rsp_item_type predict_face_uv(req_item_type d);
      longint x, y, z, ax, ay, az;
      rsp_item_type r;
      x  = longint'(d.dir_x);
      y  = longint'(d.dir_y);
      z  = longint'(d.dir_z);
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      r.face  = FACE_TOP;
      r.tex_u = '0;
      r.tex_v = '0;
      if (ax >= ay && ax >= az) begin
         if (x > 0) begin
            r.face = FACE_RIGHT;
            r.tex_u = minor_to_coord(z, x, 1'b0);
            r.tex_v = minor_to_coord(y, x, 1'b0);
         end else if (x < 0) begin
            r.face = FACE_LEFT;
            r.tex_u = minor_to_coord(z, x, 1'b0);
            r.tex_v = minor_to_coord(y, x, 1'b1);
         end
      end else if (ay >= ax && ay >= az) begin
         if (y > 0) begin
            r.face = FACE_TOP;
            r.tex_u = minor_to_coord(x, y, 1'b0);
            r.tex_v = minor_to_coord(z, y, 1'b0);
         end else begin
            r.face = FACE_BOTTOM;
            r.tex_u = minor_to_coord(x, y, 1'b1);
            r.tex_v = minor_to_coord(z, y, 1'b1);
         end
      end else begin
         if (z > 0) begin
            r.face = FACE_FRONT;
            r.tex_u = minor_to_coord(x, z, 1'b1);
            r.tex_v = minor_to_coord(y, z, 1'b0);
         end else begin
            r.face = FACE_BACK;
            r.tex_u = minor_to_coord(x, z, 1'b0);
            r.tex_v = minor_to_coord(y, z, 1'b1);
         end
      end
      return r;
   endfunction

   // Draw a direction: full range, small values, exact ties or extreme components
   function automatic req_item_type make_direction();
      req_item_type d;
      logic signed [FIELD_WIDTH-1:0] c [3];
      int kind, a, b;
      int unsigned mag_val;
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 3; i++)
         c[i] = FIELD_WIDTH'($urandom);
      if (kind == 4 || kind == 5) begin
         for (int i = 0; i < 3; i++)
            c[i] = FIELD_WIDTH'(int'($urandom_range(0, 16)) - 8);
      end else if (kind == 6 || kind == 7) begin
         mag_val = $urandom_range(1, 32767);
         a = $urandom_range(0, 2);
         b = (a + 1 + $urandom_range(0, 1)) % 3;
         c[a] = FIELD_WIDTH'(mag_val);
         c[b] = FIELD_WIDTH'(mag_val);
         c[3 - a - b] = FIELD_WIDTH'($urandom_range(0, mag_val));
         for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 1) == 1) c[i] = -c[i];
      end else if (kind >= 8) begin
         for (int i = 0; i < 3; i++)
            case ($urandom_range(0, 5))
               0: c[i] = 16'sh8000;
               1: c[i] = 16'sh7fff;
               2: c[i] = -16'sd1;
               3: c[i] = 16'sd1;
               4: c[i] = 16'sd0;
               default: c[i] = FIELD_WIDTH'($urandom);
            endcase
      end
      d.dir_x = c[0];
      d.dir_y = c[1];
      d.dir_z = c[2];
      return d;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Offer one item, wait for it to be taken, then plan the next idle gap
   task automatic offer_direction(input req_item_type item, input rsp_item_type want);
      if (idle_due > 0) begin
         req_valid <= 1'b0;
         repeat (idle_due) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_face_uv.push_back(want);
      accepted_count++;
      if (burst_left > 0) begin
         burst_left--;
         idle_due = 0;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 12);
         idle_due = (hold_left > 0) ? 0 : $urandom_range(1, 6);
      end
   endtask

   // Stimulus: reset, directed table, random directions, drain
   initial begin : stimulus
      stim_row_type row;
      req_item_type dir;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_rows[i];
         offer_direction(row.req, row.exact ? row.want : predict_face_uv(row.req));
      end
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         dir = make_direction();
         offer_direction(dir, predict_face_uv(dir));
      end
      req_valid <= 1'b0;
      while (expected_face_uv.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d directions (%0d directed), checked %0d responses, input held %0d cycles",
               accepted_count, DIRECTED_COUNT, rsp_count, input_stall_cycles);
      $display("faces reached: right %0d left %0d top %0d bottom %0d front %0d back %0d",
               face_hits[0], face_hits[1], face_hits[2], face_hits[3], face_hits[4],
               face_hits[5]);
      if (mismatch_count == 0)
         $display("[cubemap_face_uv_select] OK");
      else
         $display("[cubemap_face_uv_select] ERROR");
      $finish;
   end

   // Receiver: switch among stall patterns, and hold off once for a long stretch
   initial begin : rsp_stall_pattern
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (!hold_done && accepted_count >= HOLD_TRIGGER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(8, 60);
            end
            mode_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 2) == 0);
               2: rsp_stall <= ~rsp_stall;
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type want;
      if (!reset) begin
         if (req_valid && req_stall) input_stall_cycles++;
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (int'(rsp_item.face) < 6) face_hits[int'(rsp_item.face)]++;
            if (expected_face_uv.size() == 0) begin
               report_mismatch($sformatf("unexpected response face %0d u %h v %h",
                                         rsp_item.face, rsp_item.tex_u, rsp_item.tex_v));
            end else begin
               want = expected_face_uv.pop_front();
               if (rsp_item.face !== want.face)
                  report_mismatch($sformatf("face %0d, want %0d", rsp_item.face, want.face));
               if (rsp_item.tex_u !== want.tex_u)
                  report_mismatch($sformatf("tex_u %h, want %h", rsp_item.tex_u, want.tex_u));
               if (rsp_item.tex_v !== want.tex_v)
                  report_mismatch($sformatf("tex_v %h, want %h", rsp_item.tex_v, want.tex_v));
            end
         end
      end
   end

   // Stop a hung run
   initial begin
      #1000000;
      $display("[cubemap_face_uv_select] ERROR");
      $finish;
   end

endmodule
